FILE: hw/rtl/sts_pkg.sv
// sts_pkg: shared types and constants for the script token scanner.
// Depends on nothing; used by every module of the scanner.
package sts_pkg;

    // Source characters with a meaning of their own
    localparam logic [7:0] C_HASH  = 8'h23;  // '#'
    localparam logic [7:0] C_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_POINT = 8'h2E;  // '.'
    localparam logic [7:0] C_BSL   = 8'h5C;  // backslash
    localparam logic [7:0] C_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_LPAREN = 8'h28;
    localparam logic [7:0] C_RPAREN = 8'h29;
    localparam logic [7:0] C_LBRACK = 8'h5B;
    localparam logic [7:0] C_RBRACK = 8'h5D;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    // Token kinds
    localparam logic [2:0] K_TERM   = 3'd0;
    localparam logic [2:0] K_OPEN   = 3'd1;
    localparam logic [2:0] K_CLOSE  = 3'd2;
    localparam logic [2:0] K_SYMBOL = 3'd3;
    localparam logic [2:0] K_NUMBER = 3'd4;
    localparam logic [2:0] K_STRING = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_NUM = 2'd1;
    localparam logic [1:0] ST_UNTERM  = 2'd2;
    localparam logic [1:0] ST_EOI     = 2'd3;

    // Result queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // Scanner mode, one-hot
    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_COMMENT = 7'b0000010,
        M_CR      = 7'b0000100,
        M_MINUS   = 7'b0001000,
        M_NUMBER  = 7'b0010000,
        M_SYMBOL  = 7'b0100000,
        M_STRING  = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [1:0]  status;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [15:0] end_line;
        logic [15:0] end_column;
    } t_result;

    // All results of one input item: one, or two when 'two' is set
    typedef struct packed {
        logic    two;
        t_result res0;
        t_result res1;
    } t_entry;

endpackage

FILE: hw/rtl/script_token_scanner.sv
// script_token_scanner: top level of the streaming source tokenizer.
// Depends on sts_pkg, sts_front, sts_fifo and sts_back.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+--------------------------------------
//  source  | in        | i_valid / o_ready  | i_data_byte, i_end_of_input
//  token   | out       | o_valid / i_ready  | o_token_kind, o_status, o_start_*,
//          |           |                    | o_end_*, o_last_result
//
// One byte is taken every cycle while the result queue has room; the scan
// mode and position update in that single cycle.
// An item yields zero, one or two results; the output stage sends one per
// cycle while i_ready is high, so items with two results use two transfers.
// The first result is written into the queue at the byte's transfer edge and
// is then registered in the output stage before it shows on the outputs.
// Reset (i_rst_n low, synchronous) returns to line 1, column 1, idle mode.
// A stall on the output fills the four-entry queue, then drops o_ready.
module script_token_scanner #(
    parameter int POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_token_kind,
    output logic [1:0]  o_status,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [15:0] o_end_line,
    output logic [15:0] o_end_column,
    output logic        o_last_result
);

    // front -> queue
    logic            push;
    sts_pkg::t_entry push_entry;
    // queue -> back
    logic            pop;
    logic            q_full;
    logic            q_empty;
    sts_pkg::t_entry head_entry;
    sts_pkg::t_result result;

    // Front: classifies each byte and forms all of its results at once
    sts_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_full         (q_full),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    // Queue decouples byte intake from output stalls
    sts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: serialises entries into single result transfers
    sts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result),
        .o_last   (o_last_result)
    );

    assign o_token_kind   = result.token_kind;
    assign o_status       = result.status;
    assign o_start_line   = result.start_line;
    assign o_start_column = result.start_column;
    assign o_end_line     = result.end_line;
    assign o_end_column   = result.end_column;

endmodule

FILE: hw/rtl/sts_front.sv
// sts_front: accepts source bytes, tracks positions and scan mode, forms results.
// Depends on sts_pkg; feeds sts_fifo.
module sts_front #(
    parameter int POS_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_input,
    input  logic              i_full,
    output logic              o_push,
    output sts_pkg::t_entry   o_entry
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);

    sts_pkg::t_mode r_mode, n_mode;
    logic r_point, n_point;
    logic r_quote_sq, n_quote_sq;     // 1: single quote opened the string
    logic r_esc, n_esc;               // last string byte was an unpaired backslash
    logic r_prior_cr;
    logic r_ended, n_ended;
    logic [POS_WIDTH-1:0] r_cur_line, r_cur_col, r_prev_line, r_prev_col;
    logic [POS_WIDTH-1:0] r_tok_line, r_tok_col;
    logic [POS_WIDTH-1:0] n_cur_line, n_cur_col;

    logic accept, consume, go_idle, newline;
    logic is_digit, is_sep, is_cr, is_lf, quote_hit;
    logic have_a, have_b, b_from_tok;
    logic [2:0] kind_a, kind_b;
    logic [1:0] st_a, st_b;
    sts_pkg::t_result res_a, res_b;

    function automatic logic [15:0] to_out(input logic [POS_WIDTH-1:0] p);
        logic [POS_WIDTH+15:0] ext;
        ext = {16'd0, p};
        return ext[15:0];
    endfunction

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    assign is_cr    = (i_data_byte == sts_pkg::C_CR);
    assign is_lf    = (i_data_byte == sts_pkg::C_LF);
    assign is_digit = (i_data_byte >= sts_pkg::C_ZERO) && (i_data_byte <= sts_pkg::C_NINE);
    assign is_sep   = (i_data_byte == sts_pkg::C_SPACE)  || (i_data_byte == sts_pkg::C_TAB)
                   || is_cr || is_lf || (i_data_byte == sts_pkg::C_SEMI)
                   || (i_data_byte == sts_pkg::C_LBRACK) || (i_data_byte == sts_pkg::C_LPAREN)
                   || (i_data_byte == sts_pkg::C_LBRACE) || (i_data_byte == sts_pkg::C_RBRACK)
                   || (i_data_byte == sts_pkg::C_RPAREN) || (i_data_byte == sts_pkg::C_RBRACE)
                   || (i_data_byte == sts_pkg::C_DQUOTE) || (i_data_byte == sts_pkg::C_SQUOTE)
                   || (i_data_byte == sts_pkg::C_HASH);
    assign quote_hit = r_quote_sq ? (i_data_byte == sts_pkg::C_SQUOTE)
                                  : (i_data_byte == sts_pkg::C_DQUOTE);

    // Position after this byte; CR, or LF not after CR, opens a line
    assign newline = is_cr || (is_lf && !r_prior_cr);
    always_comb begin
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        if (newline) begin
            n_cur_col = POS_ONE;
            if (r_cur_line != POS_MAX) begin
                n_cur_line = r_cur_line + POS_ONE;
            end
        end else if (r_cur_col != POS_MAX) begin
            n_cur_col = r_cur_col + POS_ONE;
        end
    end

    // Result A: pending token closed before the byte. Result B: token at or
    // ending on the byte, or the end-of-input mark.
    always_comb begin
        n_mode     = r_mode;
        n_point    = r_point;
        n_quote_sq = r_quote_sq;
        n_esc      = r_esc;
        n_ended    = r_ended;
        consume    = 1'b0;
        go_idle    = 1'b0;
        have_a     = 1'b0;
        have_b     = 1'b0;
        b_from_tok = 1'b0;
        kind_a     = sts_pkg::K_SYMBOL;
        st_a       = sts_pkg::ST_OK;
        kind_b     = sts_pkg::K_TERM;
        st_b       = sts_pkg::ST_OK;

        if (r_ended) begin
            have_b = 1'b1;
            st_b   = sts_pkg::ST_EOI;
        end else if (i_end_of_input) begin
            unique case (r_mode)
                sts_pkg::M_NUMBER: begin
                    have_a = 1'b1;
                    kind_a = sts_pkg::K_NUMBER;
                end
                sts_pkg::M_MINUS, sts_pkg::M_SYMBOL: begin
                    have_a = 1'b1;
                end
                sts_pkg::M_STRING: begin
                    have_a = 1'b1;
                    st_a   = sts_pkg::ST_UNTERM;
                end
                default: begin
                end
            endcase
            have_b  = 1'b1;
            st_b    = sts_pkg::ST_EOI;
            n_mode  = sts_pkg::M_IDLE;
            n_ended = 1'b1;
        end else begin
            consume = 1'b1;
            unique case (r_mode)
                sts_pkg::M_IDLE: go_idle = 1'b1;
                sts_pkg::M_COMMENT: go_idle = is_cr || is_lf;
                sts_pkg::M_CR: begin
                    go_idle = 1'b1;
                    have_a  = !is_lf;
                    kind_a  = sts_pkg::K_TERM;
                end
                sts_pkg::M_MINUS: begin
                    if (is_digit) begin
                        n_point = 1'b0;
                        n_mode  = sts_pkg::M_NUMBER;
                    end else if (is_sep) begin
                        have_a  = 1'b1;
                        go_idle = 1'b1;
                    end else begin
                        n_mode = sts_pkg::M_SYMBOL;
                    end
                end
                sts_pkg::M_NUMBER: begin
                    if (i_data_byte == sts_pkg::C_POINT) begin
                        if (r_point) begin
                            have_b     = 1'b1;
                            b_from_tok = 1'b1;
                            kind_b     = sts_pkg::K_SYMBOL;
                            st_b       = sts_pkg::ST_BAD_NUM;
                            n_mode     = sts_pkg::M_IDLE;
                        end else begin
                            n_point = 1'b1;
                        end
                    end else if (!is_digit && !is_sep) begin
                        have_b     = 1'b1;
                        b_from_tok = 1'b1;
                        kind_b     = sts_pkg::K_SYMBOL;
                        st_b       = sts_pkg::ST_BAD_NUM;
                        n_mode     = sts_pkg::M_IDLE;
                    end else if (is_sep) begin
                        have_a  = 1'b1;
                        kind_a  = sts_pkg::K_NUMBER;
                        go_idle = 1'b1;
                    end
                end
                sts_pkg::M_SYMBOL: begin
                    if (is_sep) begin
                        have_a  = 1'b1;
                        go_idle = 1'b1;
                    end
                end
                sts_pkg::M_STRING: begin
                    if (quote_hit && !r_esc) begin
                        have_b     = 1'b1;
                        b_from_tok = 1'b1;
                        kind_b     = sts_pkg::K_STRING;
                        n_mode     = sts_pkg::M_IDLE;
                    end else begin
                        // a backslash pair escapes nothing
                        n_esc = (i_data_byte == sts_pkg::C_BSL) && !r_esc;
                    end
                end
                default: go_idle = 1'b1;
            endcase

            if (go_idle) begin
                n_mode = sts_pkg::M_IDLE;
                unique case (i_data_byte) inside
                    sts_pkg::C_SPACE, sts_pkg::C_TAB: begin
                    end
                    sts_pkg::C_HASH: n_mode = sts_pkg::M_COMMENT;
                    sts_pkg::C_SEMI, sts_pkg::C_LF: begin
                        have_b = 1'b1;
                        kind_b = sts_pkg::K_TERM;
                    end
                    sts_pkg::C_CR: n_mode = sts_pkg::M_CR;
                    sts_pkg::C_DQUOTE, sts_pkg::C_SQUOTE: begin
                        n_quote_sq = (i_data_byte == sts_pkg::C_SQUOTE);
                        n_esc      = 1'b0;
                        n_mode     = sts_pkg::M_STRING;
                    end
                    sts_pkg::C_LPAREN, sts_pkg::C_LBRACK, sts_pkg::C_LBRACE: begin
                        have_b = 1'b1;
                        kind_b = sts_pkg::K_OPEN;
                    end
                    sts_pkg::C_RPAREN, sts_pkg::C_RBRACK, sts_pkg::C_RBRACE: begin
                        have_b = 1'b1;
                        kind_b = sts_pkg::K_CLOSE;
                    end
                    sts_pkg::C_MINUS: n_mode = sts_pkg::M_MINUS;
                    [sts_pkg::C_ZERO:sts_pkg::C_NINE]: begin
                        n_point = 1'b0;
                        n_mode  = sts_pkg::M_NUMBER;
                    end
                    default: n_mode = sts_pkg::M_SYMBOL;
                endcase
            end
        end
    end

    // A ends at the last consumed byte; B ends at the current byte
    always_comb begin
        res_a.token_kind   = kind_a;
        res_a.status       = st_a;
        res_a.start_line   = to_out(r_tok_line);
        res_a.start_column = to_out(r_tok_col);
        res_a.end_line     = to_out(r_prev_line);
        res_a.end_column   = to_out(r_prev_col);
        res_b.token_kind   = kind_b;
        res_b.status       = st_b;
        res_b.start_line   = to_out(b_from_tok ? r_tok_line : r_cur_line);
        res_b.start_column = to_out(b_from_tok ? r_tok_col : r_cur_col);
        res_b.end_line     = to_out(r_cur_line);
        res_b.end_column   = to_out(r_cur_col);
    end

    assign o_push       = accept && (have_a || have_b);
    assign o_entry.two  = have_a && have_b;
    assign o_entry.res0 = have_a ? res_a : res_b;
    assign o_entry.res1 = res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sts_pkg::M_IDLE;
            r_point     <= 1'b0;
            r_quote_sq  <= 1'b0;
            r_esc       <= 1'b0;
            r_prior_cr  <= 1'b0;
            r_ended     <= 1'b0;
            r_cur_line  <= POS_ONE;
            r_cur_col   <= POS_ONE;
            r_prev_line <= POS_ONE;
            r_prev_col  <= POS_ONE;
            r_tok_line  <= POS_ONE;
            r_tok_col   <= POS_ONE;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_point    <= n_point;
            r_quote_sq <= n_quote_sq;
            r_esc      <= n_esc;
            r_ended    <= n_ended;
            if (go_idle) begin
                r_tok_line <= r_cur_line;
                r_tok_col  <= r_cur_col;
            end
            if (consume) begin
                r_prev_line <= r_cur_line;
                r_prev_col  <= r_cur_col;
                r_cur_line  <= n_cur_line;
                r_cur_col   <= n_cur_col;
                r_prior_cr  <= is_cr;
            end
        end
    end

endmodule

FILE: hw/rtl/sts_fifo.sv
// sts_fifo: short queue of result entries between scanner front and back.
// Depends on sts_pkg.
module sts_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sts_pkg::t_entry i_entry,
    input  logic            i_pop,
    output sts_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);

    localparam int DEPTH = sts_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    sts_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/sts_back.sv
// sts_back: output register; sends the one or two results of an entry in turn.
// Depends on sts_pkg; drains sts_fifo.
module sts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sts_pkg::t_entry  i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output sts_pkg::t_result o_result,
    output logic             o_last
);

    logic            r_valid;
    logic            r_second;
    sts_pkg::t_entry r_entry;
    logic            take;

    assign o_last   = r_second || !r_entry.two;
    assign take     = !r_valid || (i_ready && o_last);
    assign o_pop    = take && !i_empty;
    assign o_valid  = r_valid;
    assign o_result = r_second ? r_entry.res1 : r_entry.res0;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (take) begin
            r_valid  <= !i_empty;
            r_second <= 1'b0;
        end else if (i_ready) begin
            r_second <= 1'b1;
        end
    end

endmodule

FILE: hw/rtl/sts_checker.sv
// sts_checker: port-level assertions for script_token_scanner, bound to it.
// Depends on sts_pkg and the top level's port list.
module sts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_token_kind,
    input logic [1:0]  o_status,
    input logic [15:0] o_start_line,
    input logic [15:0] o_start_column,
    input logic [15:0] o_end_line,
    input logic [15:0] o_end_column,
    input logic        o_last_result
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_token_kind) && $stable(o_status)
            && $stable(o_end_column) && $stable(o_last_result))
        else $error("result changed while stalled");

    // End-of-input mark is a terminator at a single position
    a_eoi_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == sts_pkg::ST_EOI |-> o_token_kind == sts_pkg::K_TERM
            && o_start_line == o_end_line && o_start_column == o_end_column)
        else $error("malformed end-of-input result");

    // End-of-input mark is always the final result of its item
    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == sts_pkg::ST_EOI |-> o_last_result)
        else $error("end-of-input result not last");

    // Error results are reported as symbols
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sts_pkg::ST_BAD_NUM || o_status == sts_pkg::ST_UNTERM)
            |-> o_token_kind == sts_pkg::K_SYMBOL)
        else $error("error result with wrong kind");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_token_kind   (o_token_kind),
    .o_status       (o_status),
    .o_start_line   (o_start_line),
    .o_start_column (o_start_column),
    .o_end_line     (o_end_line),
    .o_end_column   (o_end_column),
    .o_last_result  (o_last_result)
);

FILE: tb/script_token_scanner_test.sv
// Self-checking testbench for script_token_scanner: byte stream in, tokens out.
// Depends on sts_pkg and the scanner RTL; needs no files or arguments.
// Expected tokens come from a behavioural scanner model kept inside this file.
module script_token_scanner_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] POS_MAX     = 16'hFFFF;
    localparam int          QUIET_LIMIT = 1000;   // cycles with no transfer at all
    localparam int          RANDOM_ITEMS = 420;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input is known from time zero.
    // ------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_end_of_input = 1'b0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_token_kind;
    logic [1:0]  o_status;
    logic [15:0] o_start_line;
    logic [15:0] o_start_column;
    logic [15:0] o_end_line;
    logic [15:0] o_end_column;
    logic        o_last_result;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    script_token_scanner i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_status       (o_status),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_end_line     (o_end_line),
        .o_end_column   (o_end_column),
        .o_last_result  (o_last_result)
    );

    // ------------------------------------------------------------------
    // Scanner model state: a private copy of everything the block tracks.
    // ------------------------------------------------------------------
    typedef struct packed {
        sts_pkg::t_result res;
        logic             last;
    } t_token_due;

    t_token_due        tokens_due [$];   // tokens still owed by the DUT, oldest first
    sts_pkg::t_result  item_res [2];     // tokens raised by the byte being modelled
    int                item_n;

    sts_pkg::t_mode mode_q = sts_pkg::M_IDLE;
    logic        point_q  = 1'b0;
    logic [7:0]  quote_q  = 8'h00;
    logic [7:0]  esc_q    = 8'h00;  // previous string byte, cleared by a double backslash
    logic [7:0]  prior_q  = 8'h00;  // last consumed byte, for CR LF pairing
    logic [15:0] line_q   = 16'd1;
    logic [15:0] col_q    = 16'd1;
    logic [15:0] pline_q  = 16'd1;
    logic [15:0] pcol_q   = 16'd1;
    logic [15:0] tline_q  = 16'd1;
    logic [15:0] tcol_q   = 16'd1;
    logic        ended_q  = 1'b0;

    int faults      = 0;
    int quiet_count = 0;
    int burst_left  = 0;
    int snk_left    = 0;

    function automatic bit is_digit(input logic [7:0] b);
        return b >= sts_pkg::C_ZERO && b <= sts_pkg::C_NINE;
    endfunction

    function automatic bit is_sep(input logic [7:0] b);
        return b == sts_pkg::C_SPACE || b == sts_pkg::C_TAB || b == sts_pkg::C_CR ||
               b == sts_pkg::C_LF || b == sts_pkg::C_SEMI || b == sts_pkg::C_LBRACK ||
               b == sts_pkg::C_LPAREN || b == sts_pkg::C_LBRACE ||
               b == sts_pkg::C_RBRACK || b == sts_pkg::C_RPAREN ||
               b == sts_pkg::C_RBRACE || b == sts_pkg::C_DQUOTE ||
               b == sts_pkg::C_SQUOTE || b == sts_pkg::C_HASH;
    endfunction

    function automatic void add_token(input logic [2:0] kind, input logic [1:0] st,
                                      input logic [15:0] sl, input logic [15:0] sc,
                                      input logic [15:0] el, input logic [15:0] ec);
        if (item_n < 2) begin
            item_res[item_n] = '{kind, st, sl, sc, el, ec};
            item_n++;
        end
    endfunction

    // Token running from its recorded start to the last consumed byte
    function automatic void add_span(input logic [2:0] kind, input logic [1:0] st);
        add_token(kind, st, tline_q, tcol_q, pline_q, pcol_q);
    endfunction

    // Move the position past one byte; CR, or LF not after CR, opens a new line
    function automatic void advance(input logic [7:0] b);
        pline_q = line_q;
        pcol_q  = col_q;
        if (b == sts_pkg::C_CR || (b == sts_pkg::C_LF && prior_q != sts_pkg::C_CR)) begin
            col_q = 16'd1;
            if (line_q != POS_MAX) line_q = line_q + 16'd1;
        end else if (col_q != POS_MAX) begin
            col_q = col_q + 16'd1;
        end
        prior_q = b;
    endfunction

    // One source byte. Modes that only close a pending token hand the same
    // byte back round the loop so that idle mode can start the next one.
    function automatic void scan_byte(input logic [7:0] b);
        bit again;
        do begin
            again = 1'b0;
            case (mode_q)
                sts_pkg::M_IDLE: begin
                    tline_q = line_q;
                    tcol_q  = col_q;
                    advance(b);
                    case (b)
                        sts_pkg::C_SPACE, sts_pkg::C_TAB: ;
                        sts_pkg::C_HASH: mode_q = sts_pkg::M_COMMENT;
                        sts_pkg::C_SEMI, sts_pkg::C_LF:
                            add_span(sts_pkg::K_TERM, sts_pkg::ST_OK);
                        sts_pkg::C_CR: mode_q = sts_pkg::M_CR;
                        sts_pkg::C_DQUOTE, sts_pkg::C_SQUOTE: begin
                            quote_q = b;
                            esc_q   = b;
                            mode_q  = sts_pkg::M_STRING;
                        end
                        sts_pkg::C_LPAREN, sts_pkg::C_LBRACK, sts_pkg::C_LBRACE:
                            add_span(sts_pkg::K_OPEN, sts_pkg::ST_OK);
                        sts_pkg::C_RPAREN, sts_pkg::C_RBRACK, sts_pkg::C_RBRACE:
                            add_span(sts_pkg::K_CLOSE, sts_pkg::ST_OK);
                        sts_pkg::C_MINUS: mode_q = sts_pkg::M_MINUS;
                        default: begin
                            if (is_digit(b)) begin
                                point_q = 1'b0;
                                mode_q  = sts_pkg::M_NUMBER;
                            end else begin
                                mode_q = sts_pkg::M_SYMBOL;
                            end
                        end
                    endcase
                end
                sts_pkg::M_COMMENT: begin
                    if (b == sts_pkg::C_CR || b == sts_pkg::C_LF) begin
                        mode_q = sts_pkg::M_IDLE;
                        again  = 1'b1;
                    end else begin
                        advance(b);
                    end
                end
                sts_pkg::M_CR: begin
                    // CR LF: the LF alone gives the terminator
                    if (b != sts_pkg::C_LF) add_span(sts_pkg::K_TERM, sts_pkg::ST_OK);
                    mode_q = sts_pkg::M_IDLE;
                    again  = 1'b1;
                end
                sts_pkg::M_MINUS: begin
                    if (is_digit(b)) begin
                        point_q = 1'b0;
                        mode_q  = sts_pkg::M_NUMBER;
                    end else if (is_sep(b)) begin
                        add_span(sts_pkg::K_SYMBOL, sts_pkg::ST_OK);
                        mode_q = sts_pkg::M_IDLE;
                    end else begin
                        mode_q = sts_pkg::M_SYMBOL;
                    end
                    again = 1'b1;
                end
                sts_pkg::M_NUMBER: begin
                    if (b == sts_pkg::C_POINT) begin
                        advance(b);
                        if (point_q) begin
                            add_span(sts_pkg::K_SYMBOL, sts_pkg::ST_BAD_NUM);
                            mode_q = sts_pkg::M_IDLE;
                        end else begin
                            point_q = 1'b1;
                        end
                    end else if (is_digit(b)) begin
                        advance(b);
                    end else if (!is_sep(b)) begin
                        // bad number ends on the offending byte
                        advance(b);
                        add_span(sts_pkg::K_SYMBOL, sts_pkg::ST_BAD_NUM);
                        mode_q = sts_pkg::M_IDLE;
                    end else begin
                        add_span(sts_pkg::K_NUMBER, sts_pkg::ST_OK);
                        mode_q = sts_pkg::M_IDLE;
                        again  = 1'b1;
                    end
                end
                sts_pkg::M_SYMBOL: begin
                    if (is_sep(b)) begin
                        add_span(sts_pkg::K_SYMBOL, sts_pkg::ST_OK);
                        mode_q = sts_pkg::M_IDLE;
                        again  = 1'b1;
                    end else begin
                        advance(b);
                    end
                end
                sts_pkg::M_STRING: begin
                    advance(b);
                    if (b == quote_q && esc_q != sts_pkg::C_BSL) begin
                        add_span(sts_pkg::K_STRING, sts_pkg::ST_OK);
                        mode_q = sts_pkg::M_IDLE;
                    end else begin
                        esc_q = (b == sts_pkg::C_BSL && esc_q == sts_pkg::C_BSL) ? 8'h00 : b;
                    end
                end
                default: begin
                    mode_q = sts_pkg::M_IDLE;
                    again  = 1'b1;
                end
            endcase
        end while (again);
    endfunction

    // Expected tokens for one accepted source item, appended to tokens_due
    function automatic void predict_tokens(input logic [7:0] b, input logic eoi);
        item_n = 0;
        if (ended_q) begin
            add_token(sts_pkg::K_TERM, sts_pkg::ST_EOI, line_q, col_q, line_q, col_q);
        end else if (eoi) begin
            // flush whatever token is still open, then the end marker
            case (mode_q)
                sts_pkg::M_NUMBER: add_span(sts_pkg::K_NUMBER, sts_pkg::ST_OK);
                sts_pkg::M_MINUS, sts_pkg::M_SYMBOL:
                    add_span(sts_pkg::K_SYMBOL, sts_pkg::ST_OK);
                sts_pkg::M_STRING: add_span(sts_pkg::K_SYMBOL, sts_pkg::ST_UNTERM);
                default: ;
            endcase
            add_token(sts_pkg::K_TERM, sts_pkg::ST_EOI, line_q, col_q, line_q, col_q);
            mode_q  = sts_pkg::M_IDLE;
            ended_q = 1'b1;
        end else begin
            scan_byte(b);
        end
        for (int i = 0; i < item_n; i++)
            tokens_due.push_back('{item_res[i], (i == item_n - 1)});
    endfunction

    // ------------------------------------------------------------------
    // Token checker: every output transfer is matched to the oldest token due.
    // ------------------------------------------------------------------
    function automatic void log_fault(input string why, input t_token_due want,
                                      input sts_pkg::t_result got);
        faults++;
        if (faults <= 10)
            $display("%0t %s: want k%0d s%0d %0d:%0d-%0d:%0d l%0b,",
                     $realtime, why, want.res.token_kind, want.res.status,
                     want.res.start_line, want.res.start_column, want.res.end_line,
                     want.res.end_column, want.last,
                     " got k%0d s%0d %0d:%0d-%0d:%0d l%0b",
                     got.token_kind, got.status, got.start_line, got.start_column,
                     got.end_line, got.end_column, o_last_result);
    endfunction

    always @(posedge i_clk) begin : check_tokens
        t_token_due       want;
        sts_pkg::t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_token_kind, o_status, o_start_line, o_start_column,
                    o_end_line, o_end_column};
            if (tokens_due.size() == 0) begin
                log_fault("token with none due", '0, got);
            end else begin
                want = tokens_due.pop_front();
                if (got.token_kind != want.res.token_kind || got.status != want.res.status ||
                    got.start_line != want.res.start_line ||
                    got.start_column != want.res.start_column ||
                    got.end_line != want.res.end_line ||
                    got.end_column != want.res.end_column || o_last_result != want.last)
                    log_fault("token mismatch", want, got);
            end
        end
    end

    // Watchdog: a run that moves nothing for too long has hung
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_count);
            $display("[script_token_scanner] ERROR");
            $finish;
        end
    end

    // Token sink: alternating ready runs and stalls, with the odd long run
    always @(posedge i_clk) begin
        if (snk_left != 0) begin
            snk_left <= snk_left - 1;
        end else begin
            i_ready  <= !i_ready;
            snk_left <= i_ready ? $urandom_range(0, 5)
                                : (($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12));
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    // One source transfer. Bursts of back-to-back items with random gaps
    // in between; valid stays high across a burst.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_ready);
        predict_tokens(b, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    // Source holds off until every token due has been seen
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
    endtask

    function automatic logic [7:0] symbol_char();
        case ($urandom_range(0, 3))
            0:       return 8'h61 + 8'($urandom_range(0, 25));   // a..z
            1:       return 8'($urandom_range(128, 255));       // high bytes are plain
            2:       return sts_pkg::C_ZERO + 8'($urandom_range(0, 9));
            default: return 8'h41 + 8'($urandom_range(0, 25));   // A..Z
        endcase
    endfunction

    function automatic logic [7:0] digit_char();
        return sts_pkg::C_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Minus before a digit, before a separator and before a letter
    task automatic test_minus_forms();
        send_text("-5 -;-x(");
    endtask

    // CR LF pair, lone CR before a byte, symbol closed by a terminator
    task automatic test_line_ends();
        send_text("\r\n\ra;");
    endtask

    // Second point, then a letter inside a number: both flagged bad
    task automatic test_number_forms();
        send_text("1..2a");
    endtask

    // Escaped quote stays inside; a double backslash escapes nothing
    task automatic test_string_escapes();
        send_text("\"\\\"\\\\\"");
    endtask

    // Comment swallowing the extreme bytes, then byte FF as a symbol
    task automatic test_comments_and_extremes();
        send_item(sts_pkg::C_HASH, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(sts_pkg::C_LF, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(sts_pkg::C_RBRACE, 1'b0);
    endtask

    // Mostly well-formed lexemes with random content, some broken ones and noise
    task automatic test_random_lexemes(input int count);
        int sent;
        int n;
        logic [7:0] q;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 11))
                0, 1: begin
                    n = $urandom_range(1, 5);
                    send_item(($urandom_range(0, 1) != 0) ? 8'h61 : 8'($urandom_range(128, 255)),
                              1'b0);
                    repeat (n - 1) send_item(symbol_char(), 1'b0);
                    sent += n;
                end
                2, 3: begin
                    if ($urandom_range(0, 2) == 0) begin
                        send_item(sts_pkg::C_MINUS, 1'b0);
                        sent++;
                    end
                    n = $urandom_range(1, 4);
                    repeat (n) send_item(digit_char(), 1'b0);
                    sent += n;
                    if ($urandom_range(0, 1) != 0) begin
                        send_item(sts_pkg::C_POINT, 1'b0);
                        n = $urandom_range(0, 3);
                        repeat (n) send_item(digit_char(), 1'b0);
                        sent += n + 1;
                    end
                end
                4: begin
                    q = ($urandom_range(0, 1) != 0) ? sts_pkg::C_DQUOTE : sts_pkg::C_SQUOTE;
                    send_item(q, 1'b0);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        case ($urandom_range(0, 5))
                            0:       send_item(sts_pkg::C_BSL, 1'b0);
                            1:       send_item(q, 1'b0);
                            2:       send_item(8'($urandom_range(0, 255)), 1'b0);
                            default: send_item(symbol_char(), 1'b0);
                        endcase
                    end
                    send_item(q, 1'b0);
                    sent += n + 2;
                end
                5: begin
                    case ($urandom_range(0, 5))
                        0: send_item(sts_pkg::C_LPAREN, 1'b0);
                        1: send_item(sts_pkg::C_LBRACK, 1'b0);
                        2: send_item(sts_pkg::C_LBRACE, 1'b0);
                        3: send_item(sts_pkg::C_RPAREN, 1'b0);
                        4: send_item(sts_pkg::C_RBRACK, 1'b0);
                        default: send_item(sts_pkg::C_RBRACE, 1'b0);
                    endcase
                    sent++;
                end
                6: begin
                    case ($urandom_range(0, 3))
                        0: send_item(sts_pkg::C_SEMI, 1'b0);
                        1: send_item(sts_pkg::C_LF, 1'b0);
                        2: send_item(sts_pkg::C_CR, 1'b0);
                        default: begin
                            send_item(sts_pkg::C_CR, 1'b0);
                            send_item(sts_pkg::C_LF, 1'b0);
                            sent++;
                        end
                    endcase
                    sent++;
                end
                7: begin
                    send_item(sts_pkg::C_HASH, 1'b0);
                    n = $urandom_range(0, 5);
                    repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
                    send_item(($urandom_range(0, 1) != 0) ? sts_pkg::C_LF : sts_pkg::C_CR,
                              1'b0);
                    sent += n + 2;
                end
                8: begin
                    send_item(sts_pkg::C_MINUS, 1'b0);
                    send_item(($urandom_range(0, 1) != 0) ? symbol_char() : sts_pkg::C_SEMI,
                              1'b0);
                    sent += 2;
                end
                9: begin
                    send_item(digit_char(), 1'b0);
                    send_item(sts_pkg::C_POINT, 1'b0);
                    send_item(($urandom_range(0, 1) != 0) ? sts_pkg::C_POINT : 8'h7A, 1'b0);
                    sent += 3;
                end
                default: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
                    sent += n;
                end
            endcase
            // usual separator between lexemes; sometimes run them together
            case ($urandom_range(0, 5))
                0:       ;
                1: begin
                    send_item(sts_pkg::C_TAB, 1'b0);
                    sent++;
                end
                default: begin
                    send_item(sts_pkg::C_SPACE, 1'b0);
                    sent++;
                end
            endcase
        end
    endtask

    // End mark after a random lead-in, at times with a token still open, then items after the end
    task automatic test_end_of_input();
        case ($urandom_range(0, 6))
            0: send_item(sts_pkg::C_SPACE, 1'b0);
            1: send_item(digit_char(), 1'b0);
            2: send_item(sts_pkg::C_MINUS, 1'b0);
            3: send_item(symbol_char(), 1'b0);
            4: send_text("\"a");                    // unterminated string
            5: send_item(sts_pkg::C_CR, 1'b0);      // trailing CR gives no terminator
            default: send_text("#z");
        endcase
        send_item(8'($urandom_range(0, 255)), 1'b1);
        send_item(8'hFF, 1'b1);
        repeat (4) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_minus_forms();
        test_line_ends();
        test_number_forms();
        test_string_escapes();
        test_comments_and_extremes();
        hold_until_drained();
        test_random_lexemes(RANDOM_ITEMS);
        hold_until_drained();
        test_random_lexemes(30);
        test_end_of_input();

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (faults == 0 && tokens_due.size() == 0) begin
            $display("[script_token_scanner] OK");
        end else begin
            $display("[script_token_scanner] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sts_pkg.sv
hw/rtl/sts_front.sv
hw/rtl/sts_fifo.sv
hw/rtl/sts_back.sv
hw/rtl/script_token_scanner.sv
hw/rtl/sts_checker.sv
tb/script_token_scanner_test.sv
